// ===== sv/hfe_pkg.sv =====
// Shared types, codes and constants of the Haar feature evaluator.
// Used by the controller, datapath and top level; depends on nothing.
`default_nettype none

package hfe_pkg;

  localparam int unsigned WIN_W_DEF = 64;
  localparam int unsigned WIN_H_DEF = 128;

  localparam int unsigned FV_W  = 22;
  localparam int unsigned GEO_W = 11;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [2:0] FT_HPAIR   = 3'd0;
  localparam logic [2:0] FT_HTRIPLE = 3'd1;
  localparam logic [2:0] FT_VPAIR   = 3'd2;
  localparam logic [2:0] FT_VTRIPLE = 3'd3;
  localparam logic [2:0] FT_QUAD    = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OUTSIDE    = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;
  localparam logic [1:0] ST_BAD_TYPE   = 2'd3;

  typedef struct packed {
    logic       command;
    logic [7:0] pixel;
    logic [2:0] feature_type;
    logic [5:0] left_x;
    logic [6:0] top_y;
    logic [6:0] cell_width;
    logic [7:0] cell_height;
  } hfe_req_t;

  typedef struct packed {
    logic signed [FV_W-1:0] feature_value;
    logic [1:0]             status;
  } hfe_rsp_t;

  typedef struct packed {
    logic accept;
    logic load_rd;
    logic load_wr;
    logic eval_init;
    logic eval_issue;
    logic out_load;
  } hfe_ctl_t;

  typedef struct packed {
    logic cmd_eval;
    logic fault;
    logic last_point;
  } hfe_sts_t;

  function automatic logic [1:0] layout_rows(input logic [2:0] ft);
    logic [1:0] r;
    unique case (ft)
      FT_VPAIR, FT_QUAD: r = 2'd2;
      FT_VTRIPLE:        r = 2'd3;
      default:           r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] layout_cols(input logic [2:0] ft);
    logic [1:0] c;
    unique case (ft)
      FT_HPAIR, FT_QUAD: c = 2'd2;
      FT_HTRIPLE:        c = 2'd3;
      default:           c = 2'd1;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hfe_ram.sv =====
// Generic single-port RAM with a registered read port.
// Used for the integral image store; depends on nothing.
`default_nettype none

module hfe_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/hfe_datapath.sv =====
// Datapath of the Haar feature evaluator: integral image build, corner
// walk, accumulation and result register. Depends on hfe_pkg and hfe_ram.
`default_nettype none

module hfe_datapath #(
  parameter int unsigned WIN_W = hfe_pkg::WIN_W_DEF,
  parameter int unsigned WIN_H = hfe_pkg::WIN_H_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hfe_pkg::hfe_req_t req_i,
  input  wire hfe_pkg::hfe_ctl_t ctl_i,
  output hfe_pkg::hfe_sts_t     sts_o,
  output logic                  done_o,
  output hfe_pkg::hfe_rsp_t     rsp_o
);

  import hfe_pkg::*;

  localparam int unsigned AREA   = WIN_W * WIN_H;
  localparam int unsigned ADDR_W = $clog2(AREA);
  localparam int unsigned CI_W   = $clog2(WIN_W);
  localparam int unsigned RI_W   = $clog2(WIN_H);
  localparam int unsigned CG_W   = CI_W + 1;
  localparam int unsigned RG_W   = RI_W + 1;
  localparam int unsigned ROW_W  = $clog2(255 * WIN_W + 1);
  localparam int unsigned INT_W  = $clog2(255 * AREA + 1);
  localparam int unsigned ACC_W  = (INT_W + 6 > FV_W + 2) ? INT_W + 6 : FV_W + 2;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (FV_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  hfe_req_t                req_q;
  logic [CI_W-1:0]         col_q, col_d;
  logic [RI_W-1:0]         rowc_q, rowc_d;
  logic [ROW_W-1:0]        row_sum_q, row_sum_d;
  logic                    complete_q, complete_d;
  logic signed [CG_W-1:0]  col_g_q, col_g_d;
  logic signed [RG_W-1:0]  row_g_q, row_g_d;
  logic [1:0]              p_q, p_d, q_q, q_d;
  logic                    pend_vld_q, pend_zero_q, pend_neg_q;
  logic [1:0]              pend_shift_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic                    done_q;
  hfe_rsp_t                rsp_q, rsp_d;

  logic [1:0]              nrows, ncols;
  logic [GEO_W-1:0]        ext_x, ext_y;
  logic [1:0]              status_c;
  logic [RI_W-1:0]         arow;
  logic [CI_W-1:0]         acol;
  logic [ADDR_W-1:0]       addr;
  logic [ROW_W-1:0]        row_new;
  logic [INT_W-1:0]        wdata, ram_rdata;
  logic                    row_two, col_two, pt_zero, pt_neg;
  logic [1:0]              pt_shift;
  logic signed [ACC_W-1:0] term;
  logic signed [FV_W-1:0]  sat_value;

  assign nrows = layout_rows(req_q.feature_type);
  assign ncols = layout_cols(req_q.feature_type);
  assign ext_x = GEO_W'(req_q.left_x) + GEO_W'(ncols) * GEO_W'(req_q.cell_width);
  assign ext_y = GEO_W'(req_q.top_y) + GEO_W'(nrows) * GEO_W'(req_q.cell_height);

  always_comb begin
    priority if (req_q.feature_type > FT_QUAD) begin
      status_c = ST_BAD_TYPE;
    end else if (!complete_q) begin
      status_c = ST_INCOMPLETE;
    end else if (req_q.cell_width == '0 || req_q.cell_height == '0 ||
                 ext_x > GEO_W'(WIN_W) || ext_y > GEO_W'(WIN_H)) begin
      status_c = ST_OUTSIDE;
    end else begin
      status_c = ST_OK;
    end
  end

  always_comb begin
    priority if (ctl_i.load_rd) begin
      arow = rowc_q - RI_W'(1);
      acol = col_q;
    end else if (ctl_i.load_wr) begin
      arow = rowc_q;
      acol = col_q;
    end else begin
      arow = row_g_q[RI_W-1:0];
      acol = col_g_q[CI_W-1:0];
    end
  end

  assign addr = ADDR_W'(arow) * ADDR_W'(WIN_W) + ADDR_W'(acol);

  assign row_new = ((col_q == '0) ? '0 : row_sum_q) + ROW_W'(req_q.pixel);
  assign wdata   = INT_W'(row_new) + ((rowc_q == '0) ? '0 : ram_rdata);

  hfe_ram #(
    .WIDTH(INT_W),
    .DEPTH(AREA)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.load_wr),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(ram_rdata)
  );

  assign row_two  = (p_q != 2'd0) && (p_q < nrows);
  assign col_two  = (q_q != 2'd0) && (q_q < ncols);
  assign pt_shift = {1'b0, row_two} + {1'b0, col_two};
  assign pt_neg   = p_q[0] ^ q_q[0];
  assign pt_zero  = row_g_q[RG_W-1] | col_g_q[CG_W-1];

  assign term = (pend_zero_q ? '0 : {{(ACC_W - INT_W){1'b0}}, ram_rdata}) <<< pend_shift_q;

  always_comb begin
    priority if (acc_q > SAT_HI) begin
      sat_value = SAT_HI[FV_W-1:0];
    end else if (acc_q < SAT_LO) begin
      sat_value = SAT_LO[FV_W-1:0];
    end else begin
      sat_value = acc_q[FV_W-1:0];
    end
  end

  always_comb begin
    col_d      = col_q;
    rowc_d     = rowc_q;
    row_sum_d  = row_sum_q;
    complete_d = complete_q;
    if (ctl_i.load_rd) begin
      complete_d = 1'b0;
    end
    if (ctl_i.load_wr) begin
      row_sum_d = row_new;
      if (col_q == CI_W'(WIN_W - 1)) begin
        col_d = '0;
        if (rowc_q == RI_W'(WIN_H - 1)) begin
          rowc_d     = '0;
          complete_d = 1'b1;
        end else begin
          rowc_d = rowc_q + RI_W'(1);
        end
      end else begin
        col_d = col_q + CI_W'(1);
      end
    end
  end

  always_comb begin
    col_g_d = col_g_q;
    row_g_d = row_g_q;
    p_d     = p_q;
    q_d     = q_q;
    acc_d   = acc_q;
    if (ctl_i.eval_init) begin
      col_g_d = CG_W'({1'b0, req_q.left_x}) - CG_W'(1);
      row_g_d = RG_W'({1'b0, req_q.top_y}) - RG_W'(1);
      p_d     = 2'd0;
      q_d     = 2'd0;
      acc_d   = '0;
    end else begin
      if (ctl_i.eval_issue) begin
        if (q_q == ncols) begin
          q_d     = 2'd0;
          col_g_d = CG_W'({1'b0, req_q.left_x}) - CG_W'(1);
          p_d     = p_q + 2'd1;
          row_g_d = row_g_q + RG_W'(req_q.cell_height);
        end else begin
          q_d     = q_q + 2'd1;
          col_g_d = col_g_q + CG_W'(req_q.cell_width);
        end
      end
      if (pend_vld_q) begin
        acc_d = pend_neg_q ? acc_q - term : acc_q + term;
      end
    end
  end

  always_comb begin
    rsp_d = rsp_q;
    if (ctl_i.out_load) begin
      rsp_d.feature_value = (status_c == ST_OK) ? sat_value : '0;
      rsp_d.status        = status_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      rowc_q     <= '0;
      row_sum_q  <= '0;
      complete_q <= 1'b0;
      pend_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      col_q      <= col_d;
      rowc_q     <= rowc_d;
      row_sum_q  <= row_sum_d;
      complete_q <= complete_d;
      pend_vld_q <= ctl_i.eval_issue;
      done_q     <= ctl_i.out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      req_q <= req_i;
    end
    col_g_q      <= col_g_d;
    row_g_q      <= row_g_d;
    p_q          <= p_d;
    q_q          <= q_d;
    acc_q        <= acc_d;
    pend_zero_q  <= pt_zero;
    pend_neg_q   <= pt_neg;
    pend_shift_q <= pt_shift;
    rsp_q        <= rsp_d;
  end

  assign sts_o.cmd_eval   = (req_i.command == CMD_EVAL);
  assign sts_o.fault      = (status_c != ST_OK);
  assign sts_o.last_point = (p_q == nrows) && (q_q == ncols);

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_issue_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.eval_issue |-> complete_q)
    else $error("Store corner read while the image is incomplete.");

  a_issue_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.eval_issue && !row_g_q[RG_W-1] && !col_g_q[CG_W-1] |->
      ({1'b0, row_g_q} < (RG_W + 1)'(WIN_H)) && ({1'b0, col_g_q} < (CG_W + 1)'(WIN_W)))
    else $error("Corner read outside the window.");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && rsp_q.status != ST_OK |-> rsp_q.feature_value == '0)
    else $error("Nonzero feature value with a fault status.");

endmodule

`default_nettype wire

// ===== sv/hfe_ctrl.sv =====
// Controller state machine of the Haar feature evaluator.
// Sequences pixel loads and feature evaluations; depends on hfe_pkg.
`default_nettype none

module hfe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire hfe_pkg::hfe_sts_t sts_i,
  output hfe_pkg::hfe_ctl_t      ctl_o,
  output logic                   busy
);

  import hfe_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_LOAD_RD   = 3'd1;
  localparam logic [2:0] S_LOAD_WR   = 3'd2;
  localparam logic [2:0] S_EVAL_CHK  = 3'd3;
  localparam logic [2:0] S_EVAL_RUN  = 3'd4;
  localparam logic [2:0] S_EVAL_TAIL = 3'd5;
  localparam logic [2:0] S_EVAL_OUT  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        ctl_o.accept = start;
        if (start) begin
          state_d = sts_i.cmd_eval ? S_EVAL_CHK : S_LOAD_RD;
        end
      end
      S_LOAD_RD: begin
        ctl_o.load_rd = 1'b1;
        state_d       = S_LOAD_WR;
      end
      S_LOAD_WR: begin
        ctl_o.load_wr = 1'b1;
        state_d       = S_IDLE;
      end
      S_EVAL_CHK: begin
        ctl_o.eval_init = 1'b1;
        state_d         = sts_i.fault ? S_EVAL_OUT : S_EVAL_RUN;
      end
      S_EVAL_RUN: begin
        ctl_o.eval_issue = 1'b1;
        if (sts_i.last_point) begin
          state_d = S_EVAL_TAIL;
        end
      end
      S_EVAL_TAIL: begin
        state_d = S_EVAL_OUT;
      end
      S_EVAL_OUT: begin
        ctl_o.out_load = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  a_load_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD_RD |=> state_q == S_LOAD_WR ##1 state_q == S_IDLE)
    else $error("Pixel load did not finish in two cycles.");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL_RUN && sts_i.last_point |=> state_q == S_EVAL_TAIL)
    else $error("Corner walk did not stop after the last corner.");

  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.out_load |=> !ctl_o.out_load && !busy)
    else $error("Result register loaded twice for one request.");

endmodule

`default_nettype wire

// ===== sv/haar_feature_evaluator.sv =====
// Top level of the Haar feature evaluator: controller, datapath and
// integral image RAM. Depends on hfe_pkg, hfe_ctrl, hfe_datapath, hfe_ram.
//
// A request is taken at a clock edge with start high and busy low. A load
// request writes the next pixel of the window in raster order into the
// integral image (one RAM read of the entry above, then one
// RAM write); it gives no result. An evaluate request walks the corner grid
// of the feature, one corner per cycle through the single RAM port; the grid
// has 6 corners for the pair layouts, 8 for the triples and 9 for the
// 2x2 layout. A request with an invalid type, an incomplete image or a
// feature outside the window skips the walk. The result is on rsp_o, marked
// by done_o, high for a single cycle, in the cycle in which busy is low again; the
// receiver cannot stall it and must take it then.
`default_nettype none

module haar_feature_evaluator #(
  parameter int unsigned WIN_W = hfe_pkg::WIN_W_DEF,
  parameter int unsigned WIN_H = hfe_pkg::WIN_H_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire hfe_pkg::hfe_req_t req_i,
  output logic                   done_o,
  output hfe_pkg::hfe_rsp_t      rsp_o
);

  import hfe_pkg::*;

  hfe_ctl_t ctl;
  hfe_sts_t sts;

  hfe_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .sts_i (sts),
    .ctl_o (ctl),
    .busy  (busy)
  );

  hfe_datapath #(
    .WIN_W(WIN_W),
    .WIN_H(WIN_H)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .ctl_i (ctl),
    .sts_o (sts),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_haar_feature_evaluator.sv =====
// Self-checking testbench for haar_feature_evaluator: loads whole and partial windows,
// evaluates features on them and checks every result against its own predictor.
// Depends on hfe_pkg and the haar_feature_evaluator RTL.
module tb_haar_feature_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  import hfe_pkg::*;

  localparam int WIN_W = WIN_W_DEF;
  localparam int WIN_H = WIN_H_DEF;
  localparam int AREA = WIN_W * WIN_H;
  localparam int FV_MAX = 2 ** (FV_W - 1) - 1;
  localparam int FV_MIN = -(2 ** (FV_W - 1));
  localparam int ITEM_CYCLES = 13;
  localparam int MAX_GAP = 10;
  localparam int TAIL_CYCLES = 16;

  typedef enum int {IMG_BARS, IMG_BINARY, IMG_NOISE} img_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic done;
  hfe_req_t feat_req = '0;
  hfe_rsp_t feat_rsp;

  haar_feature_evaluator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (feat_req),
    .done_o (done),
    .rsp_o  (feat_rsp)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  hfe_req_t pending_reqs[$];
  hfe_rsp_t expected_rsps[$];
  int unsigned sent_cnt = 0;
  int unsigned accept_cnt = 0;
  int unsigned mismatch_cnt = 0;
  longint unsigned cycle_cnt = 0;
  longint unsigned cycle_limit;
  int gap_left = 0;
  int burst_left = 0;

  logic [20:0] ii_mem [AREA];
  int unsigned fill_pos = 0;
  logic [13:0] row_acc = '0;
  bit ii_ready = 1'b0;

  function automatic void cell_grid(input logic [2:0] ft, output int rows, output int cols);
    case (ft)
      FT_HPAIR: begin
        rows = 1;
        cols = 2;
      end
      FT_HTRIPLE: begin
        rows = 1;
        cols = 3;
      end
      FT_VPAIR: begin
        rows = 2;
        cols = 1;
      end
      FT_VTRIPLE: begin
        rows = 3;
        cols = 1;
      end
      default: begin
        rows = 2;
        cols = 2;
      end
    endcase
  endfunction

  function automatic int ii_at(input int row, input int col);
    if (row < 0 || col < 0 || row >= WIN_H || col >= WIN_W) return 0;
    return int'(ii_mem[row * WIN_W + col]);
  endfunction

  function automatic int box_sum(input int x, input int y, input int w, input int h);
    return ii_at(y + h - 1, x + w - 1) - ii_at(y + h - 1, x - 1)
         - ii_at(y - 1, x + w - 1) + ii_at(y - 1, x - 1);
  endfunction

  task automatic predict_request(input hfe_req_t r);
    hfe_rsp_t rsp;
    logic [20:0] above;
    int rows, cols, x, y, w, h, v;
    if (r.command == CMD_LOAD) begin
      if (ii_ready) begin
        ii_ready = 1'b0;
        fill_pos = 0;
      end
      if (fill_pos % WIN_W == 0) row_acc = '0;
      row_acc = row_acc + r.pixel;
      above = (fill_pos >= WIN_W) ? ii_mem[fill_pos - WIN_W] : '0;
      ii_mem[fill_pos] = row_acc + above;
      fill_pos++;
      if (fill_pos == AREA) begin
        ii_ready = 1'b1;
        fill_pos = 0;
      end
    end else begin
      rsp.feature_value = '0;
      rsp.status = ST_OK;
      if (r.feature_type > FT_QUAD) begin
        rsp.status = ST_BAD_TYPE;
      end else if (!ii_ready) begin
        rsp.status = ST_INCOMPLETE;
      end else begin
        cell_grid(r.feature_type, rows, cols);
        x = int'(r.left_x);
        y = int'(r.top_y);
        w = int'(r.cell_width);
        h = int'(r.cell_height);
        if (w == 0 || h == 0 || x + cols * w > WIN_W || y + rows * h > WIN_H) begin
          rsp.status = ST_OUTSIDE;
        end else begin
          v = box_sum(x, y, w, h);
          case (r.feature_type)
            FT_HPAIR: v = v - box_sum(x + w, y, w, h);
            FT_HTRIPLE: v = v - box_sum(x + w, y, w, h) + box_sum(x + 2 * w, y, w, h);
            FT_VPAIR: v = v - box_sum(x, y + h, w, h);
            FT_VTRIPLE: v = v - box_sum(x, y + h, w, h) + box_sum(x, y + 2 * h, w, h);
            default: begin
              v = v - box_sum(x, y + h, w, h) - box_sum(x + w, y, w, h)
                + box_sum(x + w, y + h, w, h);
            end
          endcase
          if (v > FV_MAX) v = FV_MAX;
          if (v < FV_MIN) v = FV_MIN;
          rsp.feature_value = FV_W'(v);
        end
      end
      expected_rsps.insert(expected_rsps.size(), rsp);
    end
  endtask

  task automatic report_mismatch(input string what, input hfe_rsp_t want, input hfe_rsp_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t: %s: value exp %0d got %0d, status exp %0d got %0d", $time, what,
               $signed(want.feature_value), $signed(got.feature_value), want.status,
               got.status);
    end
  endtask

  always @(posedge clk_i) begin
    hfe_rsp_t want;
    cycle_cnt++;
    if (rst_ni) begin
      if (done) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("result with no request waiting", '0, feat_rsp);
        end else begin
          want = expected_rsps.pop_front();
          if (feat_rsp.feature_value !== want.feature_value ||
              feat_rsp.status !== want.status) begin
            report_mismatch("wrong result", want, feat_rsp);
          end
        end
      end
      if (start && !busy) begin
        accept_cnt++;
        predict_request(feat_req);
      end
    end
  end

  always @(negedge clk_i) begin
    hfe_req_t nxt;
    if (rst_ni) begin
      if (start && accept_cnt != sent_cnt) begin
        // Request still waiting for the block to take it.
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        feat_req <= nxt;
        start <= 1'b1;
        sent_cnt++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 64);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_load(input logic [7:0] pix);
    hfe_req_t r;
    r = hfe_req_t'(40'({$urandom, $urandom}));
    r.command = CMD_LOAD;
    r.pixel = pix;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic add_eval(input logic [2:0] ft, input logic [5:0] x, input logic [6:0] y,
                          input logic [6:0] w, input logic [7:0] h);
    hfe_req_t r;
    r.command = CMD_EVAL;
    r.pixel = 8'($urandom);
    r.feature_type = ft;
    r.left_x = x;
    r.top_y = y;
    r.cell_width = w;
    r.cell_height = h;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic add_random_eval();
    int pick, rows, cols, w, h;
    logic [2:0] ft;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      ft = 3'($urandom_range(FT_HPAIR, FT_QUAD));
      cell_grid(ft, rows, cols);
      w = $urandom_range(1, WIN_W / cols);
      h = $urandom_range(1, WIN_H / rows);
      add_eval(ft, 6'($urandom_range(0, WIN_W - cols * w)),
               7'($urandom_range(0, WIN_H - rows * h)), 7'(w), 8'(h));
    end else if (pick < 93) begin
      add_eval(3'($urandom), 6'($urandom), 7'($urandom), 7'($urandom), 8'($urandom));
    end else begin
      add_eval(FT_QUAD + 3'($urandom_range(1, 3)), 6'($urandom), 7'($urandom),
               7'($urandom_range(1, 20)), 8'($urandom_range(1, 20)));
    end
  endtask

  function automatic logic [7:0] pixel_value(input img_kind_e kind, input int idx);
    case (kind)
      IMG_BARS: return (idx % WIN_W < WIN_W / 2 || idx / WIN_W >= WIN_H / 2) ? 8'd255 : 8'd0;
      IMG_BINARY: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_image(input img_kind_e kind, input int first_idx, input int last_idx);
    for (int i = first_idx; i < last_idx; i++) begin
      add_load(pixel_value(kind, i));
      if ($urandom_range(0, 511) == 0) add_random_eval();
    end
  endtask

  task automatic build_stimulus();
    add_eval(FT_QUAD + 3'd1, 6'd0, 7'd0, 7'd1, 8'd1);
    add_eval(FT_QUAD + 3'd2, 6'd63, 7'd127, 7'd64, 8'd128);
    add_eval(FT_QUAD + 3'd3, 6'd5, 7'd5, 7'd0, 8'd0);
    add_eval(FT_HPAIR, 6'd0, 7'd0, 7'd4, 8'd4);
    for (int i = 0; i < 10; i++) add_load(pixel_value(IMG_BARS, i));
    add_eval(FT_QUAD, 6'd0, 7'd0, 7'd2, 8'd2);
    for (int i = 10; i < AREA; i++) add_load(pixel_value(IMG_BARS, i));
    add_eval(FT_HPAIR, 6'd0, 7'd0, 7'd32, 8'd128);
    add_eval(FT_HTRIPLE, 6'd1, 7'd0, 7'd21, 8'd128);
    add_eval(FT_VPAIR, 6'd0, 7'd0, 7'd64, 8'd64);
    add_eval(FT_VTRIPLE, 6'd63, 7'd2, 7'd1, 8'd42);
    add_eval(FT_QUAD, 6'd0, 7'd0, 7'd32, 8'd64);
    add_eval(FT_HPAIR, 6'd31, 7'd63, 7'd1, 8'd1);
    add_eval(FT_HPAIR, 6'd0, 7'd127, 7'd32, 8'd1);
    add_eval(FT_VPAIR, 6'd63, 7'd0, 7'd1, 8'd64);
    add_eval(FT_QUAD, 6'd63, 7'd0, 7'd1, 8'd1);
    add_eval(FT_HPAIR, 6'd0, 7'd0, 7'd0, 8'd1);
    add_eval(FT_VPAIR, 6'd0, 7'd0, 7'd1, 8'd0);
    add_eval(FT_VTRIPLE, 6'd0, 7'd127, 7'd1, 8'd1);
    add_eval(FT_HPAIR, 6'd0, 7'd0, 7'd127, 8'd255);
    add_eval(FT_QUAD + 3'd3, 6'd0, 7'd0, 7'd1, 8'd1);
    // A load after a complete window starts the next one.
    add_load(pixel_value(IMG_NOISE, 0));
    add_eval(FT_HPAIR, 6'd0, 7'd0, 7'd1, 8'd1);

    add_image(IMG_NOISE, 1, AREA);
    repeat (650) add_random_eval();
    add_image(IMG_BINARY, 0, AREA);
    repeat (600) add_random_eval();
    add_image(IMG_NOISE, 0, 200);
    repeat (5) add_random_eval();
  endtask

  function automatic bit drained();
    return pending_reqs.size() == 0 && !start && accept_cnt == sent_cnt &&
           expected_rsps.size() == 0;
  endfunction

  initial begin
    build_stimulus();
    cycle_limit = longint'(pending_reqs.size()) * (ITEM_CYCLES + MAX_GAP + 2) * 4 + 2000;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (!drained() && cycle_cnt < cycle_limit) @(posedge clk_i);
    if (!drained()) begin
      $display("FAILED: results differ");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
      if (mismatch_cnt == 0 && expected_rsps.size() == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
    end
    $finish;
  end

endmodule
